// ===== src/polynomial_multiply_top_macros.svh =====
// Assertion macros shared by the checker files of the polynomial multiplier.
// Needs signals clk and rst_n in the scope that uses them.
`ifndef POLYNOMIAL_MULTIPLY_TOP_MACROS_SVH
`define POLYNOMIAL_MULTIPLY_TOP_MACROS_SVH

// Property checked on every rising edge outside reset
`define POLYMUL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included
`define POLYMUL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/polymul_pkg.sv =====
// Package for the polynomial multiplier: widths, action codes and the
// command/status structs between controller and datapath. No dependencies.
package polymul_pkg;

    localparam int IDX_W          = 5;   // coefficient index and degree width
    localparam int PIDX_W         = 6;   // product index width
    localparam int VAL_W          = 32;  // Q16.16 coefficient width
    localparam int FRAC_W         = 16;  // fractional bits
    localparam int ACC_W          = 72;  // exact sum of up to 32 products
    localparam int IN_DATA_W      = 48;
    localparam int OUT_DATA_W     = 40;
    localparam int ACT_W          = 2;
    localparam int DEF_MAX_DEGREE = 31;

    // Action codes carried on s_tuser
    localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic              load_a;
        logic              load_b;
        logic [IDX_W-1:0]  load_addr;
        logic              issue;      // one product term this cycle
        logic              first;      // first term of a coefficient
        logic              last;       // last term of a coefficient
        logic              last_k;     // coefficient is the last of the run
        logic [IDX_W-1:0]  rd_a;
        logic [IDX_W-1:0]  rd_b;
        logic [PIDX_W-1:0] k;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic busy;  // terms in flight or a result not yet taken
    } status_t;

endpackage

// ===== src/polymul_ctrl.sv =====
// Controller of the polynomial multiplier: input handshake, load commands
// and the term sequencer. Depends on polymul_pkg.
module polymul_ctrl #(
    parameter int MAX_DEGREE = polymul_pkg::DEF_MAX_DEGREE
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [polymul_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [polymul_pkg::ACT_W-1:0]        s_tuser,
    output polymul_pkg::cmd_t                    cmd,
    input  polymul_pkg::status_t                 status
);
    import polymul_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_WAIT  = 3'b100
    } state_t;

    localparam logic [IDX_W-1:0] MAX_D = IDX_W'(MAX_DEGREE);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   da_reg, da_next, db_reg, db_next;
    logic [PIDX_W-1:0]  dsum_reg, dsum_next;
    logic [PIDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]   i_reg, i_next;

    logic               accept;
    logic [IDX_W-1:0]   in_index, in_fdeg, in_sdeg, fdeg_c, sdeg_c;
    logic [PIDX_W-1:0]  k_inc, j_full, lo_cur_full, lo_nxt_full;
    logic [IDX_W-1:0]   i_lo, i_lo_nxt, i_hi;

    // Input field unpacking
    assign in_index = s_tdata[4:0];
    assign in_fdeg  = s_tdata[41:37];
    assign in_sdeg  = s_tdata[46:42];
    assign fdeg_c   = (in_fdeg > MAX_D) ? MAX_D : in_fdeg;
    assign sdeg_c   = (in_sdeg > MAX_D) ? MAX_D : in_sdeg;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Term bounds: i runs from max(0, k-db) to min(k, da)
    assign k_inc       = k_reg + PIDX_W'(1);
    assign lo_cur_full = k_reg - {1'b0, db_reg};
    assign lo_nxt_full = k_inc - {1'b0, db_reg};
    assign i_lo        = (k_reg > {1'b0, db_reg}) ? lo_cur_full[IDX_W-1:0] : '0;
    assign i_lo_nxt    = (k_inc > {1'b0, db_reg}) ? lo_nxt_full[IDX_W-1:0] : '0;
    assign i_hi        = (k_reg < {1'b0, da_reg}) ? k_reg[IDX_W-1:0] : da_reg;
    assign j_full      = k_reg - {1'b0, i_reg};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        da_next    = da_reg;
        db_next    = db_reg;
        dsum_next  = dsum_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && s_tuser == ACT_COMPUTE)
                begin
                    da_next    = fdeg_c;
                    db_next    = sdeg_c;
                    dsum_next  = {1'b0, fdeg_c} + {1'b0, sdeg_c};
                    k_next     = '0;
                    i_next     = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                i_next = i_reg + IDX_W'(1);
                if (i_reg == i_hi)
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!status.busy)
                begin
                    if (k_reg == dsum_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        k_next     = k_inc;
                        i_next     = i_lo_nxt;
                        state_next = S_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        da_reg   <= da_next;
        db_reg   <= db_next;
        dsum_reg <= dsum_next;
        k_reg    <= k_next;
        i_reg    <= i_next;
    end

    // Commands to the datapath
    always_comb
    begin
        cmd.load_a    = accept && (s_tuser == ACT_LOAD_A) && (in_index <= MAX_D);
        cmd.load_b    = accept && (s_tuser == ACT_LOAD_B) && (in_index <= MAX_D);
        cmd.load_addr = in_index;
        cmd.issue     = (state_reg == S_ISSUE);
        cmd.first     = (i_reg == i_lo);
        cmd.last      = (i_reg == i_hi);
        cmd.last_k    = (k_reg == dsum_reg);
        cmd.rd_a      = i_reg;
        cmd.rd_b      = j_full[IDX_W-1:0];
        cmd.k         = k_reg;
    end

endmodule

// ===== src/polymul_dp.sv =====
// Datapath of the polynomial multiplier: coefficient memories, multiplier,
// wide accumulator, scaling with saturation and output register. Uses polymul_pkg.
module polymul_dp #(
    parameter int MAX_DEGREE = polymul_pkg::DEF_MAX_DEGREE
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  polymul_pkg::cmd_t                    cmd,
    input  logic [polymul_pkg::VAL_W-1:0]        coeff_value,
    output polymul_pkg::status_t                 status,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [polymul_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                                 m_tlast
);
    import polymul_pkg::*;

    localparam int DEPTH  = MAX_DEGREE + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = 2 * VAL_W;
    localparam int SCL_W  = ACC_W - FRAC_W;

    logic [VAL_W-1:0] a_mem [DEPTH];
    logic [VAL_W-1:0] b_mem [DEPTH];
    logic [VAL_W-1:0] a_rd_reg, b_rd_reg;

    logic              s1_valid_reg, s1_first_reg, s1_last_reg, s1_lastk_reg;
    logic [PIDX_W-1:0] s1_k_reg;
    logic              s2_valid_reg, s2_first_reg, s2_last_reg, s2_lastk_reg;
    logic [PIDX_W-1:0] s2_k_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]  acc_reg, acc_next, prod_ext;
    logic              fin_valid_reg, fin_lastk_reg;
    logic [PIDX_W-1:0] fin_k_reg;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg;
    logic [PIDX_W-1:0] out_k_reg;
    logic [VAL_W-1:0]  out_val_reg, sat_val;
    logic [SCL_W-1:0]  scaled;
    logic [SCL_W-VAL_W:0] scaled_top;

    // Coefficient memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
            a_mem[cmd.load_addr[ADDR_W-1:0]] <= coeff_value;
        if (cmd.load_b)
            b_mem[cmd.load_addr[ADDR_W-1:0]] <= coeff_value;
        a_rd_reg <= a_mem[cmd.rd_a[ADDR_W-1:0]];
        b_rd_reg <= b_mem[cmd.rd_b[ADDR_W-1:0]];
    end

    // Multiply and accumulate
    assign prod_next = $signed(a_rd_reg) * $signed(b_rd_reg);
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_next  = s2_first_reg ? prod_ext : (acc_reg + prod_ext);

    // Scale back to Q16.16 and saturate
    assign scaled     = acc_reg[ACC_W-1:FRAC_W];
    assign scaled_top = scaled[SCL_W-1:VAL_W-1];
    always_comb
    begin
        if ((&scaled_top) || !(|scaled_top))
            sat_val = scaled[VAL_W-1:0];
        else if (scaled[SCL_W-1])
            sat_val = {1'b1, {(VAL_W-1){1'b0}}};
        else
            sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_valid_reg)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            fin_valid_reg <= s2_valid_reg && s2_last_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and tags
    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_lastk_reg <= cmd.last_k;
        s1_k_reg     <= cmd.k;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_lastk_reg <= s1_lastk_reg;
        s2_k_reg     <= s1_k_reg;
        prod_reg     <= prod_next;
        if (s2_valid_reg)
            acc_reg <= acc_next;
        fin_lastk_reg <= s2_lastk_reg;
        fin_k_reg     <= s2_k_reg;
        if (fin_valid_reg)
        begin
            out_val_reg  <= sat_val;
            out_k_reg    <= fin_k_reg;
            out_last_reg <= fin_lastk_reg;
        end
    end

    assign status.busy = s1_valid_reg || s2_valid_reg || fin_valid_reg || out_valid_reg;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {{(OUT_DATA_W-PIDX_W-VAL_W){1'b0}}, out_val_reg, out_k_reg};
    assign m_tlast     = out_last_reg;

endmodule

// ===== src/polynomial_multiply_top.sv =====
// Top level of the polynomial multiplier: joins controller and datapath.
// Depends on polymul_pkg, polymul_ctrl and polymul_dp.
//
//  Channel | Direction | Payload
//  s_      | in        | tuser action; tdata coeff_index, coeff_value, degrees
//  m_      | out       | tdata product_index, product_value; tlast is_last
//
// A load item is written to its memory when accepted. A compute item runs
// (da+1)*(db+1) multiply-accumulate terms on one shared multiplier fed by
// one read port per memory; after the last term of each product coefficient
// the pipeline drains and the result is handed over. Input is taken only
// between runs. Stalls on m_tready hold the result and pause the run. Reset
// clears control state only; memories need a load before use.
module polynomial_multiply_top #(
    parameter int MAX_DEGREE = polymul_pkg::DEF_MAX_DEGREE
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [4:0] coeff_index, [36:5] coeff_value, [41:37] first_degree,
    // [46:42] second_degree, [47] zero
    input  logic [polymul_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] action
    input  logic [polymul_pkg::ACT_W-1:0]        s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [5:0] product_index, [37:6] product_value, [39:38] zero
    output logic [polymul_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                                 m_tlast
);
    import polymul_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    polymul_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    // Memories and arithmetic
    polymul_dp #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .coeff_value (s_tdata[36:5]),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== src/polymul_checker.sv =====
// Port-level assertions for the polynomial multiplier, bound to the top level.
// Depends on polymul_pkg and polynomial_multiply_top_macros.svh.
`include "polynomial_multiply_top_macros.svh"

module polymul_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [polymul_pkg::IN_DATA_W-1:0]    s_tdata,
    input logic [polymul_pkg::ACT_W-1:0]        s_tuser,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [polymul_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic                                 m_tlast
);
    import polymul_pkg::*;

    // No result shown while in reset
    `POLYMUL_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_tvalid, "result valid in reset")

    // A stalled result holds
    `POLYMUL_ASSERT(a_out_hold,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast),
        "stalled result changed")

    // No item taken while a result waits
    `POLYMUL_ASSERT(a_no_overlap, m_tvalid |-> !s_tready, "input taken during a run")

    // A compute item starts a run
    `POLYMUL_ASSERT(a_run_starts,
        s_tvalid && s_tready && s_tuser == ACT_COMPUTE |=> !s_tready,
        "compute item did not start a run")

    // Nothing follows the last coefficient
    `POLYMUL_ASSERT(a_run_ends,
        m_tvalid && m_tready && m_tlast |=> !m_tvalid,
        "result after last coefficient")

endmodule

bind polynomial_multiply_top polymul_checker u_polymul_checker (.*);
